@@ design/tksl_pkg.sv @@
// ----------------------------------------------------------------------------
// tksl_pkg
// Shared types, codes and helpers of the top-k score list.
// ----------------------------------------------------------------------------
package tksl_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam logic [6:0]  LEN_RST      = 7'd16;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_REJECTED   = 3'd2,
    ST_LIST_ENTRY = 3'd3,
    ST_LIST_EMPTY = 3'd4,
    ST_CLEARED    = 3'd5
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_READ = 1'b1
  } fsm_e;

  // Controller to datapath
  typedef struct packed {
    logic offer;
    logic clear;
    logic rd_empty;
    logic rd_start;
    logic rd_emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic rd_last;
  } stat_t;

  // Saturate the length register to [1, cap]
  function automatic logic [6:0] sat_len(logic [6:0] len, logic [6:0] cap);
    logic [6:0] n;
    n = len;
    if (n > cap) n = cap;
    if (n == 7'd0) n = 7'd1;
    return n;
  endfunction

endpackage

@@ design/tksl_ctrl.sv @@
// ----------------------------------------------------------------------------
// tksl_ctrl
// Command decode and readout sequencing of the top-k score list.
// ----------------------------------------------------------------------------
module tksl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       op_i,
  input  tksl_pkg::stat_t  stat_i,
  output logic             busy_o,
  output tksl_pkg::cmd_t   cmd_o
);

  tksl_pkg::fsm_e state_q, state_d;
  logic           acc;

  assign acc = start_i && (state_q == tksl_pkg::FSM_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tksl_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tksl_pkg::FSM_IDLE: begin
        if (acc && tksl_pkg::op_e'(op_i) == tksl_pkg::OP_READ && !stat_i.empty) begin
          state_d = tksl_pkg::FSM_READ;
        end
      end
      tksl_pkg::FSM_READ: begin
        if (stat_i.rd_last) state_d = tksl_pkg::FSM_IDLE;
      end
      default: state_d = tksl_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    busy_o        = (state_q == tksl_pkg::FSM_READ);
    cmd_o.rd_emit = (state_q == tksl_pkg::FSM_READ);
    if (acc) begin
      unique case (tksl_pkg::op_e'(op_i))
        tksl_pkg::OP_OFFER: cmd_o.offer = 1'b1;
        tksl_pkg::OP_CLEAR: cmd_o.clear = 1'b1;
        tksl_pkg::OP_READ: begin
          cmd_o.rd_empty = stat_i.empty;
          cmd_o.rd_start = !stat_i.empty;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ design/tksl_dp.sv @@
// ----------------------------------------------------------------------------
// tksl_dp
// Slot array with parallel compare and shift, readout counter, result word.
// ----------------------------------------------------------------------------
module tksl_dp #(
  parameter int unsigned CAPACITY = tksl_pkg::CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tksl_pkg::cmd_t       cmd_i,
  output tksl_pkg::stat_t      stat_o,
  input  logic signed [31:0]   score_i,
  input  logic [63:0]          key_i,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_len_i,
  output logic [6:0]           len_o,
  output logic                 res_valid_o,
  output logic [2:0]           status_o,
  output logic signed [31:0]   entry_score_o,
  output logic [63:0]          entry_key_o,
  output logic [6:0]           rank_o,
  output logic [5:0]           position_o,
  output logic                 last_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [6:0]  CAP7  = 7'(CAPACITY);

  logic signed [31:0] slot_score_q [CAPACITY];
  logic [63:0]        slot_key_q   [CAPACITY];
  logic [CAPACITY-1:0] filled_q;
  logic [6:0]         len_q;

  logic [CNT_W-1:0]   n_use, n_cfg;
  logic [CAPACITY-1:0] cand;
  logic               hit;
  logic [IDX_W-1:0]   pos;
  logic               dup, do_ins;

  logic [CNT_W-1:0]   rd_idx_q, rd_nxt;
  logic [IDX_W-1:0]   ri;
  logic [6:0]         rank_q, rank_new;
  logic signed [31:0] prev_q;
  logic [CAPACITY:0]  filled_ext;
  logic               rd_last;

  logic               vld_q;
  tksl_pkg::status_e  st_q;
  logic signed [31:0] osc_q;
  logic [63:0]        okey_q;
  logic [6:0]         orank_q;
  logic [5:0]         opos_q;
  logic               olast_q;

  assign n_use = CNT_W'(tksl_pkg::sat_len(len_q, CAP7));
  assign n_cfg = CNT_W'(tksl_pkg::sat_len(cfg_len_i, CAP7));

  // Slot i, if within the length in use, takes the offer if empty or if the score ties or beats it
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cand[i] = (CNT_W'(i) < n_use) && (!filled_q[i] || score_i >= slot_score_q[i]);
    end
  end

  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!hit && cand[i]) begin
        hit = 1'b1;
        pos = IDX_W'(i);
      end
    end
  end

  assign dup    = hit && filled_q[pos] && (slot_key_q[pos] == key_i);
  assign do_ins = cmd_i.offer && hit && !dup;

  // Readout bookkeeping
  assign ri         = rd_idx_q[IDX_W-1:0];
  assign rd_nxt     = rd_idx_q + 1'b1;
  assign filled_ext = {1'b0, filled_q};
  assign rd_last    = (rd_nxt >= n_use) || !filled_ext[rd_nxt];
  assign rank_new   = (rd_idx_q == '0 || slot_score_q[ri] != prev_q) ? rank_q + 7'd1 : rank_q;

  assign stat_o.empty   = !filled_q[0];
  assign stat_o.rd_last = rd_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
      len_q    <= tksl_pkg::LEN_RST;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_len_i;
        for (int i = 0; i < CAPACITY; i++) begin
          if (CNT_W'(i) >= n_cfg) filled_q[i] <= 1'b0;
        end
      end else if (cmd_i.clear) begin
        filled_q <= '0;
      end else if (do_ins) begin
        filled_q[pos] <= 1'b1;
        for (int j = 1; j < CAPACITY; j++) begin
          if (IDX_W'(j) > pos && CNT_W'(j) < n_use) filled_q[j] <= filled_q[j-1];
        end
      end
    end
  end

  // Slot payload: insert and shift down within the slots in use
  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      if (pos == '0) begin
        slot_score_q[0] <= score_i;
        slot_key_q[0]   <= key_i;
      end
      for (int j = 1; j < CAPACITY; j++) begin
        if (IDX_W'(j) == pos) begin
          slot_score_q[j] <= score_i;
          slot_key_q[j]   <= key_i;
        end else if (IDX_W'(j) > pos && CNT_W'(j) < n_use) begin
          slot_score_q[j] <= slot_score_q[j-1];
          slot_key_q[j]   <= slot_key_q[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      rank_q   <= '0;
    end else if (cmd_i.rd_start) begin
      rd_idx_q <= '0;
      rank_q   <= '0;
    end else if (cmd_i.rd_emit) begin
      rd_idx_q <= rd_nxt;
      rank_q   <= rank_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_emit) prev_q <= slot_score_q[ri];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cmd_i.offer || cmd_i.clear || cmd_i.rd_empty || cmd_i.rd_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.offer) begin
      st_q    <= !hit ? tksl_pkg::ST_REJECTED :
                 (dup ? tksl_pkg::ST_DUPLICATE : tksl_pkg::ST_INSERTED);
      osc_q   <= score_i;
      okey_q  <= key_i;
      orank_q <= '0;
      opos_q  <= hit ? 6'(pos) : 6'd0;
      olast_q <= 1'b1;
    end else if (cmd_i.clear || cmd_i.rd_empty) begin
      st_q    <= cmd_i.clear ? tksl_pkg::ST_CLEARED : tksl_pkg::ST_LIST_EMPTY;
      osc_q   <= '0;
      okey_q  <= '0;
      orank_q <= '0;
      opos_q  <= '0;
      olast_q <= 1'b1;
    end else if (cmd_i.rd_emit) begin
      st_q    <= tksl_pkg::ST_LIST_ENTRY;
      osc_q   <= slot_score_q[ri];
      okey_q  <= slot_key_q[ri];
      orank_q <= rank_new;
      opos_q  <= 6'(ri);
      olast_q <= rd_last;
    end
  end

  assign len_o         = len_q;
  assign res_valid_o   = vld_q;
  assign status_o      = st_q;
  assign entry_score_o = osc_q;
  assign entry_key_o   = okey_q;
  assign rank_o        = orank_q;
  assign position_o    = opos_q;
  assign last_o        = olast_q;

endmodule

@@ design/top_k_score_list_core.sv @@
// ----------------------------------------------------------------------------
// top_k_score_list_core
// Sorted list of the best-scoring candidates with dense-rank readout.
// ----------------------------------------------------------------------------
// An offer or a clear is accepted while the block is not busy: the slot array
// compares the score against every slot at once and shifts in place, and the
// result word appears on the following cycle, so offers may be issued every
// cycle while busy is low. A readout keeps busy high while a slot counter
// steps through the filled entries, producing one entry per cycle. Results carry
// result_valid_o for one cycle and cannot be held off; the receiver must take
// each one as it appears. Write list_length only while the block is idle.
module top_k_score_list_core #(
  parameter int unsigned CAPACITY = tksl_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] score_i,
  input  logic [63:0]        key_i,
  output logic               result_valid_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] entry_score_o,
  output logic [63:0]        entry_key_o,
  output logic [6:0]         rank_o,
  output logic [5:0]         position_o,
  output logic               last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  tksl_pkg::cmd_t  cmd;
  tksl_pkg::stat_t stat;
  logic            cfg_we;
  logic [6:0]      len;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {25'd0, len};

  tksl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (op_i),
    .stat_i (stat),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  tksl_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .score_i      (score_i),
    .key_i        (key_i),
    .cfg_we_i     (cfg_we),
    .cfg_len_i    (pwdata[6:0]),
    .len_o        (len),
    .res_valid_o  (result_valid_o),
    .status_o     (status_o),
    .entry_score_o(entry_score_o),
    .entry_key_o  (entry_key_o),
    .rank_o       (rank_o),
    .position_o   (position_o),
    .last_o       (last_o)
  );

endmodule

@@ design/tksl_chk.sv @@
// ----------------------------------------------------------------------------
// tksl_chk
// Port-level checks of the top-k score list, bound to the top level.
// ----------------------------------------------------------------------------
module tksl_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  op_i,
  input logic        result_valid_o,
  input logic [2:0]  status_o,
  input logic [6:0]  rank_o,
  input logic        last_o
);

  // An accepted offer answers on the next cycle with a single offer word
  a_offer_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == tksl_pkg::OP_OFFER) |=> (result_valid_o && last_o &&
      (status_o == tksl_pkg::ST_INSERTED || status_o == tksl_pkg::ST_DUPLICATE ||
       status_o == tksl_pkg::ST_REJECTED)))
    else $error("offer did not produce one offer result");

  // Rank is nonzero exactly on list entries
  a_rank_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((status_o == tksl_pkg::ST_LIST_ENTRY) == (rank_o != 7'd0)))
    else $error("rank inconsistent with status");

  // More entries follow only while a readout keeps the block busy
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> (busy && status_o == tksl_pkg::ST_LIST_ENTRY))
    else $error("non-final word outside a readout");

  // No word without an accepted command or a readout in progress
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(start && !busy) && !$past(busy)) |-> !result_valid_o)
    else $error("spurious result word");

endmodule

bind top_k_score_list_core tksl_chk u_tksl_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .op_i          (op_i),
  .result_valid_o(result_valid_o),
  .status_o      (status_o),
  .rank_o        (rank_o),
  .last_o        (last_o)
);
